/* rtl/nearest_palette_color_assert.svh */
// Assertion macros shared by the nearest palette color RTL.
// Each macro takes a label, the clock, the active-low reset, a trigger and a consequence.
`ifndef NEAREST_PALETTE_COLOR_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_ASSERT_SVH

`ifndef SYNTHESIS

`define NPC_ASSERT_IMPLY(lbl, clk, rst_n, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> cons) \
    else $error("nearest_palette_color: assertion failed");

`define NPC_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> cons) \
    else $error("nearest_palette_color: assertion failed");

`else

`define NPC_ASSERT_IMPLY(lbl, clk, rst_n, trig, cons)

`define NPC_ASSERT_NEXT(lbl, clk, rst_n, trig, cons)

`endif

`endif

/* rtl/npc_pkg.sv */
`timescale 1ns / 1ps

package npc_pkg;

  localparam int PAL_SIZE      = 16;
  localparam int LEAVES        = 16;
  localparam int NUM_REGS      = 4;
  localparam int WORDS_PER_REG = 4;
  localparam int WORD_W        = 16;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 8;
  localparam int REG_SEL_W     = $clog2(NUM_REGS);
  localparam int COLOR_W       = 15;
  localparam int CH_W          = 5;
  localparam int PCH_W         = 3;
  localparam int DIST_W        = 7;
  localparam int IDX_W         = 4;
  localparam int GROUP         = 4;

  localparam int SRC_B_LSB = 10;
  localparam int SRC_G_LSB = 5;
  localparam int SRC_R_LSB = 0;
  localparam int PAL_B_LSB = 9;
  localparam int PAL_G_LSB = 5;
  localparam int PAL_R_LSB = 1;

  typedef struct packed {
    logic [DIST_W-1:0] dist_sum;
    logic [IDX_W-1:0]  idx;
  } cand_t;

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    logic [CH_W-1:0] res;
    if (a > b) begin
      res = a - b;
    end else begin
      res = b - a;
    end
    return res;
  endfunction

  // Lower-index candidate keeps an exact match; otherwise the higher index
  // wins ties at equal distance.
  function automatic cand_t pick(input cand_t lo, input cand_t hi);
    cand_t res;
    if (lo.dist_sum == '0) begin
      res = lo;
    end else if (hi.dist_sum <= lo.dist_sum) begin
      res = hi;
    end else begin
      res = lo;
    end
    return res;
  endfunction

endpackage

/* rtl/npc_dist.sv */
`timescale 1ns / 1ps

module npc_dist (
  input  logic                                               clk,
  input  logic [npc_pkg::COLOR_W-1:0]                        true_color,
  input  logic [npc_pkg::NUM_REGS-1:0][npc_pkg::CFG_W-1:0]  palette,
  output npc_pkg::cand_t [npc_pkg::LEAVES-1:0]               cand_r
);

  logic [npc_pkg::CH_W-1:0] src_b;
  logic [npc_pkg::CH_W-1:0] src_g;
  logic [npc_pkg::CH_W-1:0] src_r;
  npc_pkg::cand_t [npc_pkg::LEAVES-1:0] cand_nxt;

  assign src_b = true_color[npc_pkg::SRC_B_LSB +: npc_pkg::CH_W];
  assign src_g = true_color[npc_pkg::SRC_G_LSB +: npc_pkg::CH_W];
  assign src_r = true_color[npc_pkg::SRC_R_LSB +: npc_pkg::CH_W];

  for (genvar k = 0; k < npc_pkg::LEAVES; k++) begin : g_leaf
    localparam int RegSel  = k / npc_pkg::WORDS_PER_REG;
    localparam int WordSel = k % npc_pkg::WORDS_PER_REG;

    if (k < npc_pkg::PAL_SIZE) begin : g_real
      logic [npc_pkg::WORD_W-1:0] word;
      logic [npc_pkg::CH_W-1:0]   pal_b;
      logic [npc_pkg::CH_W-1:0]   pal_g;
      logic [npc_pkg::CH_W-1:0]   pal_r;

      assign word  = palette[RegSel][WordSel*npc_pkg::WORD_W +: npc_pkg::WORD_W];
      assign pal_b = {word[npc_pkg::PAL_B_LSB +: npc_pkg::PCH_W], 2'b00};
      assign pal_g = {word[npc_pkg::PAL_G_LSB +: npc_pkg::PCH_W], 2'b00};
      assign pal_r = {word[npc_pkg::PAL_R_LSB +: npc_pkg::PCH_W], 2'b00};

      assign cand_nxt[k].dist_sum =
          npc_pkg::DIST_W'(npc_pkg::abs_diff(src_b, pal_b)) +
          npc_pkg::DIST_W'(npc_pkg::abs_diff(src_g, pal_g)) +
          npc_pkg::DIST_W'(npc_pkg::abs_diff(src_r, pal_r));
    end else begin : g_pad
      // Entries past the palette size can never be chosen.
      assign cand_nxt[k].dist_sum = '1;
    end

    assign cand_nxt[k].idx = npc_pkg::IDX_W'(k);
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
  end

endmodule

/* rtl/npc_min4.sv */
`timescale 1ns / 1ps

module npc_min4 (
  input  logic                                   clk,
  input  npc_pkg::cand_t [npc_pkg::GROUP-1:0]    cand,
  output npc_pkg::cand_t                         best_r
);

  npc_pkg::cand_t lo;
  npc_pkg::cand_t hi;
  npc_pkg::cand_t best_nxt;

  always_comb begin
    lo       = npc_pkg::pick(cand[0], cand[1]);
    hi       = npc_pkg::pick(cand[2], cand[3]);
    best_nxt = npc_pkg::pick(lo, hi);
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

endmodule

/* rtl/nearest_palette_color.sv */
`timescale 1ns / 1ps

// Nearest palette color lookup.
// A transaction enters on in_true_color at a rising edge with start high and
// busy low. busy is always low, so a new color may be given every cycle.
// The result appears on out_best_index with out_strobe high for exactly one
// cycle, after the color passes the three pipeline registers; results leave in order.
// The receiver cannot stall, and none is needed: the pipeline never holds.
// Stage one forms sixteen Manhattan distances, stage two reduces them to four
// candidates, stage three to the winner. Throughput is one color per cycle.
// The palette lives in four 64-bit registers written through cfg_we,
// cfg_index and cfg_wdata; writes to an index past the last register are
// dropped. Change the palette only while no transaction is in flight.
// Reset clears the palette to zero and empties the pipeline.

`include "nearest_palette_color_assert.svh"

module nearest_palette_color (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [npc_pkg::COLOR_W-1:0]       in_true_color,
  output logic                              out_strobe,
  output logic [npc_pkg::IDX_W-1:0]         out_best_index,
  input  logic                              cfg_we,
  input  logic [npc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [npc_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int NumGroups = npc_pkg::LEAVES / npc_pkg::GROUP;

  logic [npc_pkg::NUM_REGS-1:0][npc_pkg::CFG_W-1:0] pal_r;
  logic                                             accept;
  logic                                             v1_r;
  logic                                             v2_r;
  logic                                             v3_r;
  npc_pkg::cand_t [npc_pkg::LEAVES-1:0]             s1_r;
  npc_pkg::cand_t [NumGroups-1:0]                   s2_r;
  npc_pkg::cand_t                                   s3_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_r <= '0;
    end else if (cfg_we && (cfg_index < npc_pkg::CFG_IDX_W'(npc_pkg::NUM_REGS))) begin
      pal_r[cfg_index[npc_pkg::REG_SEL_W-1:0]] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  npc_dist u_dist (
    .clk        (clk),
    .true_color (in_true_color),
    .palette    (pal_r),
    .cand_r     (s1_r)
  );

  for (genvar g = 0; g < NumGroups; g++) begin : g_grp
    npc_min4 u_min4 (
      .clk    (clk),
      .cand   (s1_r[g*npc_pkg::GROUP +: npc_pkg::GROUP]),
      .best_r (s2_r[g])
    );
  end

  npc_min4 u_final (
    .clk    (clk),
    .cand   (s2_r),
    .best_r (s3_r)
  );

  assign out_strobe     = v3_r;
  assign out_best_index = s3_r.idx;

  `NPC_ASSERT_IMPLY(a_latency, clk, rst_n, accept, ##3 out_strobe)
  `NPC_ASSERT_IMPLY(a_no_spurious, clk, rst_n, out_strobe, $past(accept, 3))
  `NPC_ASSERT_NEXT(a_final_min, clk, rst_n, v2_r, (s3_r.dist_sum <= $past(s2_r[0].dist_sum)))

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int IDX_W   = npc_pkg::IDX_W;
  localparam int COLOR_W = npc_pkg::COLOR_W;
  localparam int CFG_W   = npc_pkg::CFG_W;
  localparam int CFG_IDX_W = npc_pkg::CFG_IDX_W;

  localparam logic [CFG_IDX_W-1:0] REG_PAL_0_3    = 0;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_4_7    = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_8_11   = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_12_15  = 3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;

  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_COLORS   = 127;

  typedef enum int {PAL_RANDOM, PAL_FEW_COLORS, PAL_ALL_ZERO, PAL_ALL_ONES} palette_kind_t;

  typedef struct {
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   index;
  } color_match_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [COLOR_W-1:0]   in_true_color;
  logic                 out_strobe;
  logic [IDX_W-1:0]     out_best_index;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  logic [CFG_W-1:0] palette_model [npc_pkg::NUM_REGS];
  logic [15:0]      pal_words [16];
  color_match_t     predicted_q [$];
  color_match_t     oldest;

  int errors;
  int colors_sent;
  int results_checked;
  int palettes_loaded;
  int quiet_cycles;

  nearest_palette_color u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_true_color  (in_true_color),
    .out_strobe     (out_strobe),
    .out_best_index (out_best_index),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [IDX_W-1:0] nearest_index(input logic [COLOR_W-1:0] color);
    logic [15:0]    word;
    logic [4:0]     sb, sg, sr, pb, pg, pr;
    int             cur_dist, best_dist;
    logic [IDX_W-1:0] best;
    bit             found, done;
    sb = color[14:10];
    sg = color[9:5];
    sr = color[4:0];
    best = '0;
    best_dist = 0;
    found = 1'b0;
    done = 1'b0;
    for (int k = 0; k < npc_pkg::PAL_SIZE; k++) begin
      if (!done) begin
        word = palette_model[k / 4][16 * (k % 4) +: 16];
        pb = {word[11:9], 2'b00};
        pg = {word[7:5], 2'b00};
        pr = {word[3:1], 2'b00};
        cur_dist = ((pb > sb) ? int'(pb - sb) : int'(sb - pb))
                 + ((pg > sg) ? int'(pg - sg) : int'(sg - pg))
                 + ((pr > sr) ? int'(pr - sr) : int'(sr - pr));
        if (!found || cur_dist <= best_dist) begin
          best = IDX_W'(k);
          best_dist = cur_dist;
          found = 1'b1;
          if (cur_dist == 0) begin
            done = 1'b1;
          end
        end
      end
    end
    return best;
  endfunction

  function automatic logic [15:0] pal_word(input logic [2:0] b, input logic [2:0] g,
                                           input logic [2:0] r);
    return {4'h0, b, 1'b0, g, 1'b0, r, 1'b0};
  endfunction

  function automatic logic [COLOR_W-1:0] color_of(input logic [15:0] word);
    return {word[11:9], 2'b00, word[7:5], 2'b00, word[3:1], 2'b00};
  endfunction

  function automatic logic [COLOR_W-1:0] mk_color(input logic [4:0] b, input logic [4:0] g,
                                                  input logic [4:0] r);
    return {b, g, r};
  endfunction

  // Monitors the configuration port and the input side to keep the palette copy and the
  // list of predicted indexes, and checks every result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe === 1'b1) begin
        if (predicted_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual best_index %0d",
                   $time, out_best_index);
          errors++;
        end else begin
          oldest = predicted_q.pop_front();
          results_checked++;
          if (out_best_index !== oldest.index) begin
            $display("%0t: best_index mismatch for color %h, expected %0d, actual %0d",
                     $time, oldest.color, oldest.index, out_best_index);
            errors++;
          end
        end
      end
      if (cfg_we && cfg_index < npc_pkg::NUM_REGS) begin
        palette_model[cfg_index[npc_pkg::REG_SEL_W-1:0]] = cfg_wdata;
      end
      if (start && !busy) begin
        predicted_q.push_back('{color: in_true_color, index: nearest_index(in_true_color)});
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, predicted_q.size());
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leaves start high so that a following transaction can go in on the next edge.
  task automatic send_color(input logic [COLOR_W-1:0] color);
    start <= 1'b1;
    in_true_color <= color;
    do @(posedge clk); while (busy !== 1'b0);
    colors_sent++;
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) begin
      in_true_color <= COLOR_W'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r >= 92) begin
      idle_cycles($urandom_range(10, 40));
    end else if (r >= 60) begin
      idle_cycles($urandom_range(1, 3));
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_palette();
    write_reg(REG_PAL_0_3, {pal_words[3], pal_words[2], pal_words[1], pal_words[0]});
    write_reg(REG_PAL_4_7, {pal_words[7], pal_words[6], pal_words[5], pal_words[4]});
    write_reg(REG_PAL_8_11, {pal_words[11], pal_words[10], pal_words[9], pal_words[8]});
    write_reg(REG_PAL_12_15, {pal_words[15], pal_words[14], pal_words[13], pal_words[12]});
    palettes_loaded++;
  endtask

  task automatic test_reset_palette();
    send_color('0);
    send_color('1);
    send_color(15'h0001);
    drain();
  endtask

  task automatic test_unused_index();
    write_reg(REG_UNUSED_LOW, '1);
    write_reg(REG_UNUSED_TOP, {4{16'hFFFF}});
    send_color('0);
    send_color('1);
    drain();
  endtask

  task automatic test_directed_palette();
    pal_words[0]  = pal_word(0, 0, 0);
    pal_words[1]  = pal_word(7, 7, 7) | 16'hF111;
    pal_words[2]  = pal_word(7, 0, 0);
    pal_words[3]  = pal_word(0, 7, 0);
    pal_words[4]  = pal_word(0, 0, 7);
    pal_words[5]  = pal_word(3, 3, 3);
    pal_words[6]  = pal_word(3, 3, 3) | 16'hF111;
    pal_words[7]  = pal_word(7, 7, 0);
    pal_words[8]  = pal_word(0, 7, 7);
    pal_words[9]  = pal_word(7, 0, 7);
    pal_words[10] = pal_word(1, 2, 3);
    pal_words[11] = pal_word(4, 5, 6);
    pal_words[12] = pal_word(6, 5, 4);
    pal_words[13] = pal_word(2, 2, 2);
    pal_words[14] = pal_word(5, 5, 5);
    pal_words[15] = pal_word(5, 5, 5);
    load_palette();
    send_color('0);
    send_color('1);
    send_color(color_of(pal_words[1]));
    send_color(color_of(pal_words[2]));
    send_color(color_of(pal_words[3]));
    send_color(color_of(pal_words[4]));
    // A duplicated exact match goes to the lower entry, a shared near miss to the higher.
    send_color(mk_color(12, 12, 12));
    send_color(mk_color(13, 12, 12));
    send_color(mk_color(20, 20, 20));
    send_color(mk_color(21, 20, 20));
    send_color(mk_color(31, 0, 0));
    send_color(mk_color(0, 31, 0));
    send_color(mk_color(0, 0, 31));
    send_color(mk_color(31, 0, 31));
    send_color(15'h5555);
    send_color(15'h2AAA);
    drain();
  endtask

  task automatic fill_palette(input palette_kind_t kind);
    logic [15:0] choices [3];
    for (int c = 0; c < 3; c++) begin
      choices[c] = 16'($urandom);
    end
    for (int k = 0; k < 16; k++) begin
      case (kind)
        PAL_RANDOM: begin
          pal_words[k] = 16'($urandom);
        end
        PAL_FEW_COLORS: begin
          pal_words[k] = choices[$urandom_range(0, 2)] ^ (16'($urandom) & 16'hF111);
        end
        PAL_ALL_ZERO: begin
          pal_words[k] = '0;
        end
        default: begin
          pal_words[k] = '1;
        end
      endcase
    end
  endtask

  task automatic send_random_colors(input int n, input bit with_gaps);
    logic [15:0] word;
    int r;
    for (int i = 0; i < n; i++) begin
      word = pal_words[$urandom_range(0, 15)];
      r = $urandom_range(0, 9);
      if (r < 4) begin
        send_color(COLOR_W'($urandom));
      end else if (r < 7) begin
        send_color(color_of(word));
      end else begin
        send_color(mk_color({word[11:9], 2'($urandom)}, {word[7:5], 2'($urandom)},
                            {word[3:1], 2'($urandom)}));
      end
      if (with_gaps) begin
        random_gap();
      end
    end
  endtask

  task automatic test_random_palettes();
    palette_kind_t kind;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        2:       kind = PAL_ALL_ZERO;
        5:       kind = PAL_ALL_ONES;
        default: kind = (p % 2 == 0) ? PAL_RANDOM : PAL_FEW_COLORS;
      endcase
      fill_palette(kind);
      load_palette();
      send_random_colors(PHASE_COLORS, (p % 4) != 3);
      drain();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_true_color <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    quiet_cycles <= 0;
    errors = 0;
    colors_sent = 0;
    results_checked = 0;
    palettes_loaded = 0;
    for (int r = 0; r < npc_pkg::NUM_REGS; r++) begin
      palette_model[r] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_palette();
    test_unused_index();
    test_directed_palette();
    test_random_palettes();
    drain();
    $display("tb_top: %0d colors sent and %0d indexes checked over %0d palettes",
             colors_sent, results_checked, palettes_loaded);
    $display("tb_top: palettes included reset, all zero, all ones, duplicates and ignored bits");
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/npc_pkg.sv
rtl/npc_dist.sv
rtl/npc_min4.sv
rtl/nearest_palette_color.sv
sim/tb_top.sv
